// ===== rtl/ngts_pkg.sv =====
// Package for the n-gram token splitter: shared types, constants and helpers.
// No dependencies; imported by every module of the block.
`default_nettype none

package ngts_pkg;

  localparam int unsigned MAX_WINDOW  = 8;
  localparam int unsigned OFFSET_BITS = 16;
  localparam int unsigned RING_BITS   = $clog2(MAX_WINDOW);
  localparam int unsigned CHARS_BITS  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned WIN_BITS    = 4;
  localparam int unsigned LEN_BITS    = 3;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX   = '1;
  localparam logic [WIN_BITS-1:0]    WINDOW_RESET = WIN_BITS'(2);

  // UTF-8 lead byte thresholds
  localparam logic [7:0] LEAD4_MIN = 8'hF0;
  localparam logic [7:0] LEAD3_MIN = 8'hE0;
  localparam logic [7:0] LEAD2_MIN = 8'hC0;

  typedef enum logic [1:0] {
    CLS_SPACE = 2'd0,
    CLS_DIGIT = 2'd1,
    CLS_ALPHA = 2'd2,
    CLS_OTHER = 2'd3
  } cls_e;

  typedef struct packed {
    logic                   last;
    logic [OFFSET_BITS-1:0] tok_end;
    logic [OFFSET_BITS-1:0] tok_start;
  } tok_t;

  // Up to two tokens produced by one byte, in delivery order
  typedef struct packed {
    logic [1:0] num;
    tok_t       tok1;
    tok_t       tok0;
  } push_t;

  function automatic logic [OFFSET_BITS-1:0] sat_add(
    input logic [OFFSET_BITS-1:0] a,
    input logic [LEN_BITS-1:0]    b
  );
    logic [OFFSET_BITS:0] s;
    s = {1'b0, a} + (OFFSET_BITS+1)'(b);
    return s[OFFSET_BITS] ? OFFSET_MAX : s[OFFSET_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ngts_classify.sv =====
// Byte classifier: ASCII class and UTF-8 character length of one byte.
// Depends on ngts_pkg.
`default_nettype none

module ngts_classify
  import ngts_pkg::*;
(
  input  logic [7:0]          byte_i,
  output cls_e                cls_o,
  output logic [LEN_BITS-1:0] len_o
);

  always_comb begin
    if (byte_i <= 8'h20 || byte_i == 8'h7F) begin
      cls_o = CLS_SPACE;
    end else if (byte_i >= 8'h30 && byte_i <= 8'h39) begin
      cls_o = CLS_DIGIT;
    end else if ((byte_i >= 8'h41 && byte_i <= 8'h5A) ||
                 (byte_i >= 8'h61 && byte_i <= 8'h7A)) begin
      cls_o = CLS_ALPHA;
    end else begin
      cls_o = CLS_OTHER;
    end
  end

  always_comb begin
    if (byte_i >= LEAD4_MIN) begin
      len_o = LEN_BITS'(4);
    end else if (byte_i >= LEAD3_MIN) begin
      len_o = LEN_BITS'(3);
    end else if (byte_i >= LEAD2_MIN) begin
      len_o = LEN_BITS'(2);
    end else begin
      len_o = LEN_BITS'(1);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ngts_core.sv =====
// Tokenizer core: input register, run state, start ring and token formation.
// Depends on ngts_pkg and ngts_classify.
`default_nettype none

module ngts_core
  import ngts_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          in_byte_i,
  input  logic                in_fin_i,
  input  logic                room_i,
  input  logic                cfg_we_i,
  input  logic [WIN_BITS-1:0] cfg_wdata_i,
  output push_t               push_o,
  output logic                busy_o
);

  logic                   valid_q, valid_d;
  logic [7:0]             byte_q;
  logic                   fin_q;
  logic [WIN_BITS-1:0]    window_q;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  cls_e                   run_cls_q, run_cls_d;
  logic [OFFSET_BITS-1:0] run_start_q, run_start_d;
  logic [LEN_BITS-2:0]    trail_q, trail_d;
  logic [CHARS_BITS-1:0]  chars_q, chars_d;
  logic [RING_BITS-1:0]   ptr_q, ptr_d;
  logic [OFFSET_BITS-1:0] ring_q [MAX_WINDOW];
  logic                   ring_we;
  logic [RING_BITS-1:0]   ring_waddr;

  cls_e                   cls;
  logic [LEN_BITS-1:0]    len;
  logic                   fire;

  ngts_classify u_classify (
    .byte_i (byte_q),
    .cls_o  (cls),
    .len_o  (len)
  );

  assign fire       = valid_q && room_i;
  assign in_ready_o = !valid_q || fire;
  assign busy_o     = valid_q;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (fire) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_i;
      fin_q  <= in_fin_i;
    end
  end

  always_comb begin
    logic                   chg;
    logic [RING_BITS-1:0]   ptr_eff;
    logic [CHARS_BITS-1:0]  chars_eff;
    logic [CHARS_BITS-1:0]  chars_new;
    logic [CHARS_BITS-1:0]  n;
    logic [RING_BITS-1:0]   idx;
    logic [OFFSET_BITS-1:0] gram_start;
    logic                   tok_a, tok_b, tok_c;
    tok_t                   ta, tb, tc;

    chg        = 1'b0;
    ptr_eff    = ptr_q;
    chars_eff  = chars_q;
    chars_new  = chars_q;
    idx        = '0;
    gram_start = pos_q;
    tok_a      = 1'b0;
    tok_b      = 1'b0;
    tok_c      = 1'b0;

    // Clamp the window to 1..MAX_WINDOW
    if (window_q == '0) begin
      n = CHARS_BITS'(1);
    end else if (CHARS_BITS'(window_q) > CHARS_BITS'(MAX_WINDOW)) begin
      n = CHARS_BITS'(MAX_WINDOW);
    end else begin
      n = CHARS_BITS'(window_q);
    end

    pos_d       = pos_q;
    run_cls_d   = run_cls_q;
    run_start_d = run_start_q;
    trail_d     = trail_q;
    chars_d     = chars_q;
    ptr_d       = ptr_q;
    ring_we     = 1'b0;
    ring_waddr  = ptr_q;

    if (trail_q != '0) begin
      // Continuation byte: take it without looking at its class
      trail_d = trail_q - 1'b1;
    end else begin
      chg = (cls != run_cls_q);
      if (chg) begin
        tok_a       = (run_cls_q == CLS_DIGIT) || (run_cls_q == CLS_ALPHA);
        run_cls_d   = cls;
        run_start_d = pos_q;
        ptr_eff     = '0;
        chars_eff   = '0;
        chars_d     = '0;
        ptr_d       = '0;
      end
      if (cls == CLS_OTHER) begin
        trail_d    = (LEN_BITS-1)'(len - 1'b1);
        ring_we    = 1'b1;
        ring_waddr = ptr_eff;
        ptr_d      = ptr_eff + 1'b1;
        chars_new  = (chars_eff < CHARS_BITS'(MAX_WINDOW)) ? chars_eff + 1'b1 : chars_eff;
        chars_d    = chars_new;
        idx        = ptr_eff + RING_BITS'(1) - RING_BITS'(n);
        // A one-character window starts at the byte being written now
        gram_start = (n == CHARS_BITS'(1)) ? pos_q : ring_q[idx];
        tok_b      = (chars_new >= n);
      end
    end

    if (fin_q) begin
      tok_c       = (run_cls_d == CLS_DIGIT) || (run_cls_d == CLS_ALPHA);
      pos_d       = '0;
      run_cls_d   = CLS_SPACE;
      trail_d     = '0;
      chars_d     = '0;
      ptr_d       = '0;
    end else begin
      pos_d = sat_add(pos_q, LEN_BITS'(1));
    end

    ta = '{last: 1'b0, tok_end: pos_q, tok_start: run_start_q};
    tb = '{last: 1'b0, tok_end: sat_add(pos_q, len), tok_start: gram_start};
    tc = '{last: 1'b0, tok_end: sat_add(pos_q, LEN_BITS'(1)), tok_start: run_start_d};
    if (fin_q) begin
      run_start_d = '0;
    end

    // Pack the tokens in order; at most two of the three can occur
    push_o = '0;
    if (tok_a) begin
      push_o.tok0 = ta;
      if (tok_b) begin
        push_o.tok1 = tb;
        push_o.num  = 2'd2;
      end else if (tok_c) begin
        push_o.tok1 = tc;
        push_o.num  = 2'd2;
      end else begin
        push_o.num  = 2'd1;
      end
    end else if (tok_b) begin
      push_o.tok0 = tb;
      if (tok_c) begin
        push_o.tok1 = tc;
        push_o.num  = 2'd2;
      end else begin
        push_o.num  = 2'd1;
      end
    end else if (tok_c) begin
      push_o.tok0 = tc;
      push_o.num  = 2'd1;
    end
    if (push_o.num == 2'd2) begin
      push_o.tok1.last = 1'b1;
    end else begin
      push_o.tok0.last = 1'b1;
    end
    if (!fire) begin
      push_o.num = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      window_q    <= WINDOW_RESET;
      pos_q       <= '0;
      run_cls_q   <= CLS_SPACE;
      run_start_q <= '0;
      trail_q     <= '0;
      chars_q     <= '0;
      ptr_q       <= '0;
    end else begin
      valid_q <= valid_d;
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
      if (fire) begin
        pos_q       <= pos_d;
        run_cls_q   <= run_cls_d;
        run_start_q <= run_start_d;
        trail_q     <= trail_d;
        chars_q     <= chars_d;
        ptr_q       <= ptr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && ring_we) begin
      ring_q[ring_waddr] <= pos_q;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ngts_out_queue.sv =====
// Result queue: takes up to two tokens a cycle, hands out one per beat.
// Depends on ngts_pkg.
`default_nettype none

module ngts_out_queue
  import ngts_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  push_t                push_i,
  output logic                 room_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output tok_t                 tok_o,
  output logic [QCNT_BITS-1:0] count_o
);

  tok_t                 mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_q, rd_q;
  logic [QCNT_BITS-1:0] cnt_q, cnt_d;
  logic                 pop;

  assign valid_o = (cnt_q != '0);
  assign tok_o   = mem_q[rd_q];
  assign pop     = valid_o && ready_i;
  assign room_o  = (cnt_q <= QCNT_BITS'(QUEUE_DEPTH - 2));
  assign count_o = cnt_q;

  assign cnt_d = cnt_q + QCNT_BITS'(push_i.num) - QCNT_BITS'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + QPTR_BITS'(push_i.num);
      rd_q  <= rd_q + QPTR_BITS'(pop);
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_q] <= push_i.tok0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_q + 1'b1] <= push_i.tok1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ngram_token_splitter.sv =====
// Top level of the n-gram token splitter; instantiates ngts_core and
// ngts_out_queue, and uses ngts_pkg for types and constants.
//
// Text enters one byte per beat on the slave stream, tlast marking the final
// byte of a text. Digit runs and letter runs each give one token when they
// end; runs of other characters (UTF-8 aware by lead byte) give every window
// of window_chars characters as a token. Each token beat on the master stream
// carries start and end byte offsets; tlast flags the last token caused by
// one input byte. Throughput is one byte per cycle while the queue has room:
// a byte is held in the input register, then the core updates run state and
// pushes zero, one or two tokens into a four-entry result queue. The master
// side drains one token per cycle while m_axis_tready is high; the core holds
// its byte whenever the queue has fewer than two free entries. window_chars
// is written through cfg_wr_en_i/cfg_wr_data_i; the user must do so only
// while idle, as the block itself does not enforce it.
`default_nettype none

module ngram_token_splitter
  import ngts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: window_chars
  input  logic        cfg_wr_en_i,
  input  logic [3:0]  cfg_wr_data_i,
  // Slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tlast,   // final_byte
  // Master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] token_start, [31:16] token_end
  output logic        m_axis_tlast    // last_of_item
);

  push_t                push;
  logic                 room;
  logic                 busy;
  tok_t                 head;
  logic [QCNT_BITS-1:0] q_count;

  // Input register, run state and token formation
  ngts_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_fin_i    (s_axis_tlast),
    .room_i      (room),
    .cfg_we_i    (cfg_wr_en_i),
    .cfg_wdata_i (cfg_wr_data_i),
    .push_o      (push),
    .busy_o      (busy)
  );

  // Decouple token production from the downstream beat rate
  ngts_out_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .tok_o   (head),
    .count_o (q_count)
  );

  assign m_axis_tdata = {head.tok_end, head.tok_start};
  assign m_axis_tlast = head.last;

  // Queue never overflows
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= QCNT_BITS'(QUEUE_DEPTH))
    else $error("result queue overflow");

  // Tokens only pushed when the queue had room for two
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.num != 2'd0) |-> (busy && room))
    else $error("token pushed without room");

  // An empty input register always takes the next beat
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> s_axis_tready)
    else $error("input stalled while empty");

  // A token never ends before it starts
  a_tok_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (head.tok_end >= head.tok_start))
    else $error("token end precedes start");

endmodule

`default_nettype wire
